// ----- rtl/core/spgd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package spgd_pkg;

  // Store size and number format.
  localparam int MAX_DIM_DEF = 64;
  localparam int FRAC_BITS   = 16;

  // Field widths.
  localparam int ACT_W     = 2;
  localparam int P_W       = 22;
  localparam int RHO_W     = 32;
  localparam int VOX_W     = 6;
  localparam int STAT_W    = 2;
  localparam int ACC_W     = 48;
  localparam int EXT_W     = 7;
  localparam int CFG_IDX_W = 2;

  localparam logic [EXT_W-1:0] GRID_RESET = 7'd64;

  // Kernel datapath widths.
  localparam int SQ_W  = 2 * P_W + 2;
  localparam int R_W   = SQ_W / 2;
  localparam int NUM_W = R_W + FRAC_BITS;
  localparam int U_W   = FRAC_BITS + 2;
  localparam int W_W   = FRAC_BITS + 1;
  localparam int ADD_W = RHO_W + 1;

  // Action codes.
  localparam logic [ACT_W-1:0] ACT_DEPOSIT = 2'd0;
  localparam logic [ACT_W-1:0] ACT_READ    = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAR   = 2'd2;

  // Status codes.
  localparam logic [STAT_W-1:0] ST_DEPOSITED = 2'd0;
  localparam logic [STAT_W-1:0] ST_SKIPPED   = 2'd1;
  localparam logic [STAT_W-1:0] ST_READ_DATA = 2'd2;
  localparam logic [STAT_W-1:0] ST_CLEARED   = 2'd3;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_Z = 2'd2;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic [P_W-1:0]   pos_x;
    logic [P_W-1:0]   pos_y;
    logic [P_W-1:0]   pos_z;
    logic [P_W-1:0]   smoothing_len;
    logic [RHO_W-1:0] density;
    logic [VOX_W-1:0] voxel_x;
    logic [VOX_W-1:0] voxel_y;
    logic [VOX_W-1:0] voxel_z;
  } in_item_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [ACC_W-1:0]  voxel_value;
    logic              saturated;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [EXT_W-1:0]     value;
  } cfg_item_t;

  typedef struct packed {
    logic             start;
    logic [P_W-1:0]   dx;
    logic [P_W-1:0]   dy;
    logic [P_W-1:0]   dz;
    logic [P_W-1:0]   h;
    logic [RHO_W-1:0] rho;
  } kern_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [ADD_W-1:0] addend;
  } kern_rsp_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_SETUP, S_VOX, S_KWAIT, S_WRITE, S_RDREQ, S_RDDATA, S_DONE
  } ctrl_state_t;

  typedef enum logic [3:0] {
    K_IDLE, K_SQ, K_SQRT, K_DIV, K_SEL, K_MA, K_MB, K_POLY, K_RHO, K_DONE
  } kern_state_t;

endpackage

`default_nettype wire

// ----- rtl/core/spgd_stream_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface spgd_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/sph_particle_grid_deposit_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Payload                                      Handshake
// req      in   action, pos_x/y/z, smoothing_len, density,   valid/ready
//               voxel_x/y/z
// rsp      out  status, voxel_value, saturated               valid/ready
// cfg      in   index, value (grid_x, grid_y, grid_z)        valid/ready
//
// For a deposit, each covered voxel runs a shared kernel unit (3 square steps,
// 23 root steps, 39 divide steps, then multiply steps) around one
// read-modify-write of the grid memory. A clear sweeps the whole memory;
// after reset the same sweep runs before the first item is taken.
// A finished result sits in an output register; the next item is taken
// while it waits, and a further result waits until that register is free.
module sph_particle_grid_deposit_core #(
  parameter int MAX_DIM = spgd_pkg::MAX_DIM_DEF
) (
  input logic           clk,
  input logic           rst,
  spgd_stream_if.sink   req,
  spgd_stream_if.source rsp,
  spgd_stream_if.sink   cfg
);

  localparam int DEPTH  = MAX_DIM * MAX_DIM * MAX_DIM;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int F      = spgd_pkg::FRAC_BITS;
  localparam int P_W    = spgd_pkg::P_W;
  localparam int IW     = spgd_pkg::EXT_W;
  localparam int ACC_W  = spgd_pkg::ACC_W;
  localparam int S_W    = (P_W + 1 > IW + F) ? P_W + 1 : IW + F;

  spgd_pkg::ctrl_state_t state, state_next;

  logic [IW-1:0]       grid_x, grid_y, grid_z;
  spgd_pkg::in_item_t  in_r;
  spgd_pkg::out_item_t res_r, out_d;
  logic                out_v;
  logic [ADDR_W-1:0]   clr_addr;
  logic                clr_rep;
  logic                sat_acc;
  logic [IW-1:0]       idx [3];

  logic [P_W-1:0]      p [3];
  logic [IW-1:0]       grid [3];
  logic [IW-1:0]       lo [3], hi [3];
  logic [2:0]          ax_ok, ax_empty, ax_last;
  logic [P_W-1:0]      dd [3];
  logic                all_ok, any_empty, last_vox;
  logic [ADDR_W-1:0]   vaddr, raddr;
  logic                rd_inrange;
  logic                clr_last, slot_free;
  logic [ACC_W:0]      sum;
  logic                sat_now;
  logic [ACC_W-1:0]    acc_new;

  logic [ADDR_W-1:0]   ram_addr;
  logic                ram_we, ram_re;
  logic [ACC_W-1:0]    ram_wdata, ram_rdata;

  spgd_pkg::kern_req_t kreq;
  spgd_pkg::kern_rsp_t krsp;

  // Configuration registers.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_x <= spgd_pkg::GRID_RESET;
      grid_y <= spgd_pkg::GRID_RESET;
      grid_z <= spgd_pkg::GRID_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.data.index)
        spgd_pkg::CFG_GRID_X: grid_x <= cfg.data.value;
        spgd_pkg::CFG_GRID_Y: grid_y <= cfg.data.value;
        spgd_pkg::CFG_GRID_Z: grid_z <= cfg.data.value;
        default: ;
      endcase
    end
  end

  // Per-axis bounds, covered range and offset to the current voxel.
  assign p[0]    = in_r.pos_x;
  assign p[1]    = in_r.pos_y;
  assign p[2]    = in_r.pos_z;
  assign grid[0] = grid_x;
  assign grid[1] = grid_y;
  assign grid[2] = grid_z;

  for (genvar a = 0; a < 3; a++) begin : g_axis
    logic [IW-1:0]  ext;
    logic [S_W-1:0] ph, ipos, pe;
    logic [P_W-1:0] pmh;

    always_comb begin
      ext         = (grid[a] > MAX_DIM) ? IW'(MAX_DIM) : grid[a];
      ph          = S_W'(p[a]) + S_W'(in_r.smoothing_len);
      pmh         = p[a] - in_r.smoothing_len;
      ax_ok[a]    = (ph < S_W'({ext, {F{1'b0}}})) && (p[a] > in_r.smoothing_len);
      lo[a]       = IW'(pmh >> F) + 1'b1;
      hi[a]       = IW'(ph >> F);
      ax_empty[a] = lo[a] > hi[a];
      ax_last[a]  = idx[a] == hi[a];
      ipos        = S_W'({idx[a], {F{1'b0}}});
      pe          = S_W'(p[a]);
      dd[a]       = (pe > ipos) ? P_W'(pe - ipos) : P_W'(ipos - pe);
    end
  end

  assign all_ok    = &ax_ok;
  assign any_empty = |ax_empty;
  assign last_vox  = &ax_last;

  assign vaddr = ADDR_W'((idx[0] * MAX_DIM + idx[1]) * MAX_DIM + idx[2]);
  assign raddr = ADDR_W'((in_r.voxel_x * MAX_DIM + in_r.voxel_y) * MAX_DIM
                         + in_r.voxel_z);
  assign rd_inrange = (in_r.voxel_x < MAX_DIM) && (in_r.voxel_y < MAX_DIM)
                      && (in_r.voxel_z < MAX_DIM);
  assign clr_last   = clr_addr == ADDR_W'(DEPTH - 1);
  assign slot_free  = !out_v || rsp.ready;

  // Saturating accumulate of the kernel result.
  assign sum     = {1'b0, ram_rdata} + (ACC_W + 1)'(krsp.addend);
  assign sat_now = sum[ACC_W];
  assign acc_new = sat_now ? {ACC_W{1'b1}} : sum[ACC_W-1:0];

  // Kernel request.
  assign kreq.dx  = dd[0];
  assign kreq.dy  = dd[1];
  assign kreq.dz  = dd[2];
  assign kreq.h   = in_r.smoothing_len;
  assign kreq.rho = in_r.density;

  spgd_kernel u_kernel (
    .clk  (clk),
    .rst  (rst),
    .kreq (kreq),
    .krsp (krsp)
  );

  spgd_ram #(
    .WIDTH (ACC_W),
    .DEPTH (DEPTH)
  ) u_grid (
    .clk   (clk),
    .addr  (ram_addr),
    .we    (ram_we),
    .wdata (ram_wdata),
    .re    (ram_re),
    .rdata (ram_rdata)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      spgd_pkg::S_CLEAR: begin
        if (clr_last) state_next = clr_rep ? spgd_pkg::S_DONE : spgd_pkg::S_IDLE;
      end
      spgd_pkg::S_IDLE: begin
        if (req.valid) begin
          case (req.data.action)
            spgd_pkg::ACT_DEPOSIT: state_next = spgd_pkg::S_SETUP;
            spgd_pkg::ACT_READ:    state_next = spgd_pkg::S_RDREQ;
            spgd_pkg::ACT_CLEAR:   state_next = spgd_pkg::S_CLEAR;
            default:               state_next = spgd_pkg::S_DONE;
          endcase
        end
      end
      spgd_pkg::S_SETUP: begin
        state_next = (all_ok && !any_empty) ? spgd_pkg::S_VOX : spgd_pkg::S_DONE;
      end
      spgd_pkg::S_VOX:    state_next = spgd_pkg::S_KWAIT;
      spgd_pkg::S_KWAIT:  if (krsp.done) state_next = spgd_pkg::S_WRITE;
      spgd_pkg::S_WRITE:  state_next = last_vox ? spgd_pkg::S_DONE : spgd_pkg::S_VOX;
      spgd_pkg::S_RDREQ:  state_next = spgd_pkg::S_RDDATA;
      spgd_pkg::S_RDDATA: state_next = spgd_pkg::S_DONE;
      spgd_pkg::S_DONE:   if (slot_free) state_next = spgd_pkg::S_IDLE;
      default:            state_next = spgd_pkg::S_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    req.ready  = state == spgd_pkg::S_IDLE;
    kreq.start = state == spgd_pkg::S_VOX;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_addr   = vaddr;
    ram_wdata  = acc_new;
    unique case (state)
      spgd_pkg::S_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_addr;
        ram_wdata = '0;
      end
      spgd_pkg::S_VOX:   ram_re = 1'b1;
      spgd_pkg::S_WRITE: ram_we = 1'b1;
      spgd_pkg::S_RDREQ: begin
        ram_re   = rd_inrange;
        ram_addr = raddr;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= spgd_pkg::S_CLEAR;
      clr_addr <= '0;
      clr_rep  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == spgd_pkg::S_CLEAR) begin
        clr_addr <= clr_last ? '0 : clr_addr + 1'b1;
        if (clr_last) clr_rep <= 1'b0;
      end else if (state == spgd_pkg::S_IDLE && req.valid
                   && req.data.action == spgd_pkg::ACT_CLEAR) begin
        clr_rep <= 1'b1;
      end
    end
  end

  // Item capture, voxel walk and staged result.
  always_ff @(posedge clk) begin
    case (state)
      spgd_pkg::S_IDLE: begin
        if (req.valid) begin
          in_r    <= req.data;
          sat_acc <= 1'b0;
          res_r   <= '{status: spgd_pkg::ST_SKIPPED, voxel_value: '0, saturated: 1'b0};
        end
      end
      spgd_pkg::S_CLEAR: begin
        res_r <= '{status: spgd_pkg::ST_CLEARED, voxel_value: '0, saturated: 1'b0};
      end
      spgd_pkg::S_SETUP: begin
        if (all_ok) begin
          res_r <= '{status: spgd_pkg::ST_DEPOSITED, voxel_value: '0, saturated: 1'b0};
        end
        idx[0] <= lo[0];
        idx[1] <= lo[1];
        idx[2] <= lo[2];
      end
      spgd_pkg::S_WRITE: begin
        sat_acc <= sat_acc | sat_now;
        res_r   <= '{status: spgd_pkg::ST_DEPOSITED, voxel_value: '0,
                     saturated: sat_acc | sat_now};
        if (!ax_last[0]) begin
          idx[0] <= idx[0] + 1'b1;
        end else begin
          idx[0] <= lo[0];
          if (!ax_last[1]) begin
            idx[1] <= idx[1] + 1'b1;
          end else begin
            idx[1] <= lo[1];
            idx[2] <= idx[2] + 1'b1;
          end
        end
      end
      spgd_pkg::S_RDDATA: begin
        res_r <= '{status: spgd_pkg::ST_READ_DATA,
                   voxel_value: rd_inrange ? ram_rdata : '0, saturated: 1'b0};
      end
      default: ;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (state == spgd_pkg::S_DONE && slot_free) begin
      out_v <= 1'b1;
    end else if (rsp.ready) begin
      out_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == spgd_pkg::S_DONE && slot_free) begin
      out_d <= res_r;
    end
  end

  assign rsp.valid = out_v;
  assign rsp.data  = out_d;

  // A grid write-back follows the kernel result directly.
  a_write_after_kernel: assert property (@(posedge clk) disable iff (rst)
    state == spgd_pkg::S_WRITE |-> $past(krsp.done))
    else $error("grid write-back without a kernel result");

  // The kernel is started only when it is free.
  a_kernel_free: assert property (@(posedge clk) disable iff (rst)
    kreq.start |-> !krsp.busy)
    else $error("kernel started while busy");

  // One item at a time: ready drops after an item is taken.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("second item taken while one is at work");

  // No deposit write while the clearing sweep runs.
  a_clear_exclusive: assert property (@(posedge clk) disable iff (rst)
    state == spgd_pkg::S_CLEAR |-> !kreq.start && !krsp.busy)
    else $error("kernel active during clearing sweep");

endmodule

`default_nettype wire

// ----- rtl/core/spgd_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module spgd_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic                     we,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single port with a registered read that holds between reads.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/spgd_kernel.sv -----
`timescale 1ns / 1ps
`default_nettype none

module spgd_kernel (
  input  logic                clk,
  input  logic                rst,
  input  spgd_pkg::kern_req_t kreq,
  output spgd_pkg::kern_rsp_t krsp
);

  localparam int F     = spgd_pkg::FRAC_BITS;
  localparam int P_W   = spgd_pkg::P_W;
  localparam int SQ_W  = spgd_pkg::SQ_W;
  localparam int R_W   = spgd_pkg::R_W;
  localparam int NUM_W = spgd_pkg::NUM_W;
  localparam int U_W   = spgd_pkg::U_W;
  localparam int W_W   = spgd_pkg::W_W;
  localparam int RHO_W = spgd_pkg::RHO_W;
  localparam int Q_W   = 2 * U_W - F;
  localparam int T_W   = Q_W + U_W - F;
  localparam int A_W   = T_W + 2;
  localparam int CNT_W = $clog2(NUM_W + 1);
  localparam logic [U_W-1:0] ONE = U_W'(1) << F;
  localparam logic [U_W-1:0] TWO = U_W'(1) << (F + 1);

  spgd_pkg::kern_state_t state, state_next;

  logic [CNT_W-1:0]     cnt;
  logic [P_W-1:0]       d0, d1, d2, h_r;
  logic [RHO_W-1:0]     rho_r;
  logic [SQ_W-1:0]      sq, bitr, res;
  logic [NUM_W-1:0]     num, quo;
  logic [P_W:0]         rem;
  logic [U_W-1:0]       x;
  logic                 lo_br;
  logic [2*U_W-1:0]     m;
  logic [Q_W-1:0]       q2;
  logic [Q_W+U_W-1:0]   m2;
  logic [W_W-1:0]       w;
  logic [RHO_W+W_W-1:0] prod;

  logic [2*P_W-1:0] dsq;
  logic [SQ_W-1:0]  trial, res_nx, sq_nx;
  logic [P_W:0]     rem_sh;
  logic             qbit;
  logic [P_W:0]     rem_nx;
  logic             quo_big, quo_lo;
  logic [2*U_W-1:0] mxx;
  logic [Q_W+U_W-1:0] mqx;
  logic [T_W-1:0]   t;
  logic [A_W-1:0]   pa, pb;
  logic [W_W-1:0]   w_poly;

  // Squares accumulate through one multiplier.
  assign dsq = d0 * d0;

  // One root digit per cycle.
  always_comb begin
    trial = res + bitr;
    if (sq >= trial) begin
      sq_nx  = sq - trial;
      res_nx = (res >> 1) + bitr;
    end else begin
      sq_nx  = sq;
      res_nx = res >> 1;
    end
  end

  // One quotient bit per cycle, restoring.
  always_comb begin
    rem_sh = {rem[P_W-1:0], num[NUM_W-1]};
    qbit   = rem_sh >= {1'b0, h_r};
    rem_nx = qbit ? rem_sh - {1'b0, h_r} : rem_sh;
  end

  assign quo_big = quo >= NUM_W'(TWO);
  assign quo_lo  = quo <= NUM_W'(ONE);
  assign mxx     = x * x;
  assign mqx     = m[2*U_W-1:F] * x;

  // Spline polynomial from the registered powers.
  always_comb begin
    t  = m2[Q_W+U_W-1:F];
    pa = A_W'(ONE) + ((A_W'(t) + (A_W'(t) << 1)) >> 2);
    pb = (A_W'(q2) + (A_W'(q2) << 1)) >> 1;
    if (lo_br) begin
      w_poly = (pa > pb) ? W_W'(pa - pb) : '0;
    end else begin
      w_poly = W_W'(t >> 2);
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      spgd_pkg::K_IDLE: if (kreq.start) state_next = spgd_pkg::K_SQ;
      spgd_pkg::K_SQ:   if (cnt == CNT_W'(2)) state_next = spgd_pkg::K_SQRT;
      spgd_pkg::K_SQRT: if (cnt == CNT_W'(R_W - 1)) state_next = spgd_pkg::K_DIV;
      spgd_pkg::K_DIV:  if (cnt == CNT_W'(NUM_W - 1)) state_next = spgd_pkg::K_SEL;
      spgd_pkg::K_SEL:  state_next = quo_big ? spgd_pkg::K_RHO : spgd_pkg::K_MA;
      spgd_pkg::K_MA:   state_next = spgd_pkg::K_MB;
      spgd_pkg::K_MB:   state_next = spgd_pkg::K_POLY;
      spgd_pkg::K_POLY: state_next = spgd_pkg::K_RHO;
      spgd_pkg::K_RHO:  state_next = spgd_pkg::K_DONE;
      spgd_pkg::K_DONE: state_next = spgd_pkg::K_IDLE;
      default:          state_next = spgd_pkg::K_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    krsp.busy   = state != spgd_pkg::K_IDLE;
    krsp.done   = state == spgd_pkg::K_DONE;
    krsp.addend = prod[RHO_W+W_W-1:F];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= spgd_pkg::K_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      spgd_pkg::K_IDLE: begin
        d0    <= kreq.dx;
        d1    <= kreq.dy;
        d2    <= kreq.dz;
        h_r   <= kreq.h;
        rho_r <= kreq.rho;
        sq    <= '0;
        cnt   <= '0;
      end
      spgd_pkg::K_SQ: begin
        sq <= sq + SQ_W'(dsq);
        d0 <= d1;
        d1 <= d2;
        if (cnt == CNT_W'(2)) begin
          cnt  <= '0;
          bitr <= SQ_W'(1) << (SQ_W - 2);
          res  <= '0;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
      spgd_pkg::K_SQRT: begin
        sq   <= sq_nx;
        res  <= res_nx;
        bitr <= bitr >> 2;
        if (cnt == CNT_W'(R_W - 1)) begin
          cnt <= '0;
          num <= {res_nx[R_W-1:0], {F{1'b0}}};
          rem <= '0;
          quo <= '0;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
      spgd_pkg::K_DIV: begin
        rem <= rem_nx;
        quo <= {quo[NUM_W-2:0], qbit};
        num <= num << 1;
        cnt <= cnt + 1'b1;
      end
      spgd_pkg::K_SEL: begin
        lo_br <= quo_lo;
        x     <= quo_lo ? quo[U_W-1:0] : TWO - quo[U_W-1:0];
        if (quo_big) w <= '0;
      end
      spgd_pkg::K_MA: m <= mxx;
      spgd_pkg::K_MB: begin
        q2 <= m[2*U_W-1:F];
        m2 <= mqx;
      end
      spgd_pkg::K_POLY: w <= w_poly;
      spgd_pkg::K_RHO:  prod <= rho_r * w;
      default: ;
    endcase
  end

endmodule

`default_nettype wire
